[design/gcrt_pkg.sv]
package gcrt_pkg;

    // configuration register indexes
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_PRIME_ZERO    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRIME_ONE     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PRIME_TWO     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PRIME_THREE   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_INVERSE_ONE   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_INVERSE_TWO   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_INVERSE_THREE = 3'd6;

    localparam int WordW = 64;

    // one coefficient as it waits in the front queue
    typedef struct packed {
        logic             final_coeff;
        logic [WordW-1:0] residue_d;
        logic [WordW-1:0] residue_c;
        logic [WordW-1:0] residue_b;
        logic [WordW-1:0] residue_a;
    } t_item;

    // back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_P01,
        S_P012,
        S_RX,
        S_RR,
        S_MD,
        S_RT,
        S_MX,
        S_ADD,
        S_EMIT
    } t_state;

endpackage

[design/garner_crt_carry_stream.sv]
// the time from the input transfer to the first limb is set by the shared remainder
// unit (four bits a cycle, 960 bits an item) and the 32x32 multiplier; items are
// worked one at a time, one limb per output transfer (four limbs after a final
// coefficient), and a two-entry queue takes items meanwhile
// reset: i_rst_n is synchronous, active low; clears queue, sequencer, carry window
// and all configuration registers
module garner_crt_carry_stream (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gcrt_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [63:0]                   i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [255:0]                  s_axis_tdata,  // residue_a, residue_b, residue_c, residue_d
    input  logic                          s_axis_tlast,  // final_coeff
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,  // limb
    output logic                          m_axis_tlast   // last_limb
);
    import gcrt_pkg::*;

    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    gcrt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    gcrt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tlast    (m_axis_tlast)
    );

endmodule

[design/gcrt_front.sv]
module gcrt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [255:0]         s_axis_tdata,  // residue_a, residue_b, residue_c, residue_d
    input  logic                 s_axis_tlast,  // final_coeff
    output logic                 o_q_valid,
    output gcrt_pkg::t_item      o_q_item,
    input  logic                 i_q_pop
);
    import gcrt_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_item      w_in;

    // classify the incoming transfer into an item
    always_comb begin
        w_in.residue_a   = s_axis_tdata[63:0];
        w_in.residue_b   = s_axis_tdata[127:64];
        w_in.residue_c   = s_axis_tdata[191:128];
        w_in.residue_d   = s_axis_tdata[255:192];
        w_in.final_coeff = s_axis_tlast;
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_cnt != 2'd0);
    assign w_pop         = i_q_pop && o_q_valid;
    assign o_q_item      = r_q[r_rp];

    // two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

[design/gcrt_mac.sv]
module gcrt_mac (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_t,
    input  logic [191:0] i_m,
    input  logic [255:0] i_a,
    input  logic [2:0]   i_nh,
    output logic         o_done,
    output logic [255:0] o_res
);
    logic [63:0]         r_t;
    logic [5:0][31:0]    r_m;
    logic [255:0]        r_acc;
    logic [63:0]         r_prod;
    logic [2:0]          r_sh;
    logic                r_pv;
    logic [3:0]          r_j;
    logic [3:0]          r_np;
    logic                r_busy;
    logic                r_done;
    logic [31:0]         w_th;
    logic [31:0]         w_mh;
    logic [2:0]          w_mi;
    logic [255:0]        w_shp;

    // select the halves for the next partial product
    assign w_mi  = {1'b0, r_j[2:1]} + {2'b0, r_j[3] ? 1'b0 : 1'b0} + (r_j[3] ? 3'd4 : 3'd0);
    assign w_th  = r_j[0] ? r_t[63:32] : r_t[31:0];
    assign w_mh  = r_m[w_mi];
    assign w_shp = {192'b0, r_prod} << {r_sh, 5'b0};

    assign o_done = r_done;
    assign o_res  = r_acc;

    // 32x32 partial product, then shifted accumulate in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_j    <= 4'd0;
            r_np   <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_t    <= i_t;
                r_m    <= i_m;
                r_acc  <= i_a;
                r_j    <= 4'd0;
                r_np   <= {i_nh, 1'b0};
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
            end else begin
                r_pv <= r_busy;
                if (r_busy) begin
                    r_prod <= {32'b0, w_th} * {32'b0, w_mh};
                    r_sh   <= {2'b0, r_j[0]} + w_mi;
                    r_j    <= r_j + 4'd1;
                    if (r_j == r_np - 4'd1) begin
                        r_busy <= 1'b0;
                    end
                end
                if (r_pv) begin
                    r_acc <= r_acc + w_shp;
                    if (!r_busy) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

[design/gcrt_red.sv]
module gcrt_red (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [191:0] i_w,
    input  logic [1:0]   i_nw,
    input  logic [63:0]  i_p,
    output logic         o_done,
    output logic [63:0]  o_res
);
    logic [191:0] r_w;
    logic [63:0]  r_r;
    logic [63:0]  r_p;
    logic [5:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [63:0]  w_r;
    logic         w_top;

    // four restoring remainder steps per cycle, top bits first
    always_comb begin
        w_r = r_r;
        for (int k = 0; k < 4; k++) begin
            w_top = w_r[63];
            w_r   = {w_r[62:0], r_w[191-k]};
            if (w_top || (w_r >= r_p)) begin
                w_r = w_r - r_p;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_p == 64'd0) ? 64'd0 : r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                case (i_nw)
                    2'd1:    r_w <= {i_w[63:0], 128'b0};
                    2'd2:    r_w <= {i_w[127:0], 64'b0};
                    default: r_w <= i_w;
                endcase
                r_cnt  <= {i_nw, 4'b0};
                r_r    <= 64'd0;
                r_p    <= i_p;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r   <= w_r;
                r_w   <= r_w << 4;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[design/gcrt_back.sv]
module gcrt_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gcrt_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [63:0]                       i_cfg_data,
    input  logic                              i_q_valid,
    input  gcrt_pkg::t_item                   i_q_item,
    output logic                              o_q_pop,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [63:0]                       o_tdata,
    output logic                              o_tlast
);
    import gcrt_pkg::*;

    t_state       r_state;
    t_state       n_state;
    logic         r_mstart;
    logic         n_mstart;
    logic         r_rstart;
    logic         n_rstart;

    logic [63:0]  r_p0, r_p1, r_p2, r_p3, r_inv1, r_inv2, r_inv3;
    t_item        r_item;
    logic [127:0] r_p01;
    logic [191:0] r_p012;
    logic [255:0] r_x;
    logic [63:0]  r_rx;
    logic [63:0]  r_rr;
    logic [127:0] r_md;
    logic [63:0]  r_t;
    logic [1:0]   r_stg;
    logic [63:0]  r_limb;
    logic [2:0][63:0] r_win;
    logic [1:0]   r_oi;

    logic [63:0]  w_pk;
    logic [63:0]  w_invk;
    logic [63:0]  w_resk;
    logic [191:0] w_mk;
    logic [63:0]  w_dig;
    logic         w_mdone;
    logic [255:0] w_mres;
    logic         w_rdone;
    logic [63:0]  w_rres;
    logic [63:0]  w_mt;
    logic [191:0] w_mm;
    logic [255:0] w_ma;
    logic [2:0]   w_mnh;
    logic [191:0] w_rw;
    logic [1:0]   w_rnw;
    logic [192:0] w_sum;
    logic         w_emit_end;

    // per-stage operands of the garner step
    always_comb begin
        case (r_stg)
            2'd1: begin
                w_pk = r_p1; w_invk = r_inv1; w_resk = r_item.residue_b;
                w_mk = {128'b0, r_p0};
            end
            2'd2: begin
                w_pk = r_p2; w_invk = r_inv2; w_resk = r_item.residue_c;
                w_mk = {64'b0, r_p01};
            end
            default: begin
                w_pk = r_p3; w_invk = r_inv3; w_resk = r_item.residue_d;
                w_mk = r_p012;
            end
        endcase
    end

    // modular difference of the two reduced values
    assign w_dig = (r_rr >= r_rx) ? (r_rr - r_rx) : (r_rr - r_rx + w_pk);

    // multiplier operand selection
    always_comb begin
        w_mt  = r_t;
        w_mm  = w_mk;
        w_ma  = 256'b0;
        w_mnh = {r_stg, 1'b0};
        case (r_state)
            S_P01: begin
                w_mt = r_p1; w_mm = {128'b0, r_p0}; w_mnh = 3'd2;
            end
            S_P012: begin
                w_mt = r_p2; w_mm = {64'b0, r_p01}; w_mnh = 3'd4;
            end
            S_MD: begin
                w_mt = w_dig; w_mm = {128'b0, w_invk}; w_mnh = 3'd2;
            end
            default: begin
                w_ma = r_x;
            end
        endcase
    end

    // reducer operand selection
    always_comb begin
        case (r_state)
            S_RR: begin
                w_rw = {128'b0, w_resk}; w_rnw = 2'd1;
            end
            S_RT: begin
                w_rw = {64'b0, r_md}; w_rnw = 2'd2;
            end
            default: begin
                w_rw = r_x[191:0]; w_rnw = r_stg;
            end
        endcase
    end

    gcrt_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_t     (w_mt),
        .i_m     (w_mm),
        .i_a     (w_ma),
        .i_nh    (w_mnh),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    gcrt_red u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_rstart),
        .i_w     (w_rw),
        .i_nw    (w_rnw),
        .i_p     (w_pk),
        .o_done  (w_rdone),
        .o_res   (w_rres)
    );

    // window add: low limb leaves, window moves down a word
    assign w_sum = {1'b0, r_win[2], r_win[1], r_win[0]} + {1'b0, r_x[191:0]};

    assign w_emit_end = i_tready && ((r_oi == 2'd3) || ((r_oi == 2'd0) && !r_item.final_coeff));

    // output word select
    assign o_tvalid = (r_state == S_EMIT);
    assign o_tlast  = (r_oi == 2'd3);
    always_comb begin
        case (r_oi)
            2'd0:    o_tdata = r_limb;
            2'd1:    o_tdata = r_win[0];
            2'd2:    o_tdata = r_win[1];
            default: o_tdata = r_win[2];
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mstart <= 1'b0;
            r_rstart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mstart <= n_mstart;
            r_rstart <= n_rstart;
        end
    end

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_mstart = 1'b0;
        n_rstart = 1'b0;
        o_q_pop  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_state  = S_P01;
                    n_mstart = 1'b1;
                end
            end
            S_P01: begin
                if (w_mdone) begin
                    n_state = S_P012; n_mstart = 1'b1;
                end
            end
            S_P012: begin
                if (w_mdone) begin
                    n_state = S_RX; n_rstart = 1'b1;
                end
            end
            S_RX: begin
                if (w_rdone) begin
                    n_state = S_RR; n_rstart = 1'b1;
                end
            end
            S_RR: begin
                if (w_rdone) begin
                    n_state = S_MD; n_mstart = 1'b1;
                end
            end
            S_MD: begin
                if (w_mdone) begin
                    n_state = S_RT; n_rstart = 1'b1;
                end
            end
            S_RT: begin
                if (w_rdone) begin
                    n_state = S_MX; n_mstart = 1'b1;
                end
            end
            S_MX: begin
                if (w_mdone) begin
                    if (r_stg == 2'd3) begin
                        n_state = S_ADD;
                    end else begin
                        n_state = S_RX; n_rstart = 1'b1;
                    end
                end
            end
            S_ADD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0 <= '0; r_p1 <= '0; r_p2 <= '0; r_p3 <= '0;
            r_inv1 <= '0; r_inv2 <= '0; r_inv3 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRIME_ZERO:    r_p0   <= i_cfg_data;
                CFG_PRIME_ONE:     r_p1   <= i_cfg_data;
                CFG_PRIME_TWO:     r_p2   <= i_cfg_data;
                CFG_PRIME_THREE:   r_p3   <= i_cfg_data;
                CFG_INVERSE_ONE:   r_inv1 <= i_cfg_data;
                CFG_INVERSE_TWO:   r_inv2 <= i_cfg_data;
                CFG_INVERSE_THREE: r_inv3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid) r_item <= i_q_item;
        if (r_state == S_P01 && w_mdone) r_p01 <= w_mres[127:0];
        if (r_state == S_P012 && w_mdone) begin
            r_p012 <= w_mres[191:0];
            r_x    <= {192'b0, r_item.residue_a};
        end
        if (r_state == S_RX && w_rdone) r_rx <= w_rres;
        if (r_state == S_RR && w_rdone) r_rr <= w_rres;
        if (r_state == S_MD && w_mdone) r_md <= w_mres[127:0];
        if (r_state == S_RT && w_rdone) r_t  <= w_rres;
        if (r_state == S_MX && w_mdone) r_x  <= w_mres;
        if (r_state == S_ADD) r_limb <= w_sum[63:0];
    end

    // stage counter, carry window and output index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= 2'd1;
            r_win <= '0;
            r_oi  <= 2'd0;
        end else begin
            if (r_state == S_P012 && w_mdone) begin
                r_stg <= 2'd1;
            end
            if (r_state == S_MX && w_mdone && r_stg != 2'd3) begin
                r_stg <= r_stg + 2'd1;
            end
            if (r_state == S_ADD) begin
                r_win[0] <= w_sum[127:64];
                r_win[1] <= w_sum[191:128];
                r_win[2] <= r_x[255:192] + {63'b0, w_sum[192]};
            end
            if (r_state == S_EMIT && i_tready) begin
                if (w_emit_end) begin
                    r_oi <= 2'd0;
                    if (r_oi == 2'd3) begin
                        r_win <= '0;
                    end
                end else begin
                    r_oi <= r_oi + 2'd1;
                end
            end
        end
    end

    // window words go out only after a final coefficient
    a_flush_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_oi != 2'd0) |-> r_item.final_coeff)
        else $error("window word emitted for a non-final coefficient");

    // the multiplier only finishes in a state that waits for it
    a_mac_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdone |-> (r_state == S_P01 || r_state == S_P012 ||
                     r_state == S_MD || r_state == S_MX))
        else $error("multiplier done outside a multiply state");

    // the stage counter never leaves one to three
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg != 2'd0)
        else $error("garner stage counter out of range");

endmodule
